>>> rtl/core/ymr_pkg.sv
// ymodem receiver package: codes, result type and crc helper
// no dependencies
`timescale 1ns / 1ps
package ymr_pkg;
  localparam int SHORT_BLOCK_BYTES = 128;
  localparam int LONG_BLOCK_BYTES = 1024;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [2:0] PH_STOP = 3'd0;
  localparam logic [2:0] PH_INIT = 3'd1;
  localparam logic [2:0] PH_HEAD = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_END = 3'd4;

  localparam logic [2:0] K_TX = 3'd0;
  localparam logic [2:0] K_PAYLOAD = 3'd1;
  localparam logic [2:0] K_VERDICT = 3'd2;
  localparam logic [2:0] K_SIZE = 3'd3;
  localparam logic [2:0] K_NAME = 3'd4;
  localparam logic [2:0] K_END = 3'd5;
  localparam logic [2:0] K_ERROR = 3'd6;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_POLL = 8'h43;

  localparam logic [1:0] REG_INIT_TO = 2'd0;
  localparam logic [1:0] REG_RECV_TO = 2'd1;
  localparam logic [1:0] REG_POLL = 2'd2;
  localparam logic [1:0] REG_LONG = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [7:0]  data_byte;
    logic [7:0]  block_number;
    logic        accepted;
    logic [31:0] file_bytes;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
    result_t    r2;
  } batch_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic result_t mk(input logic [2:0] kind, input logic [7:0] tx,
                                 input logic [7:0] data, input logic [7:0] blk,
                                 input logic acc, input logic [31:0] size,
                                 input logic [1:0] err);
    result_t r;
    r.kind = kind;
    r.tx_byte = tx;
    r.data_byte = data;
    r.block_number = blk;
    r.accepted = acc;
    r.file_bytes = size;
    r.error_code = err;
    r.last = 1'b0;
    return r;
  endfunction
endpackage

>>> rtl/core/ymr_if.sv
// valid/ready channel interfaces for the ymodem receiver
// depends on nothing but logic types
`timescale 1ns / 1ps
interface ymr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  modport source(output valid, action, rx_byte, input ready);
  modport sink(input valid, action, rx_byte, output ready);
endinterface

interface ymr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  tx_byte;
  logic [7:0]  data_byte;
  logic [7:0]  block_number;
  logic        accepted;
  logic [31:0] file_bytes;
  logic [1:0]  error_code;
  logic        last;
  modport source(output valid, kind, tx_byte, data_byte, block_number, accepted,
                 file_bytes, error_code, last, input ready);
  modport sink(input valid, kind, tx_byte, data_byte, block_number, accepted,
               file_bytes, error_code, last, output ready);
endinterface

interface ymr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/ymodem_receiver.sv
// ymodem receiver top level: config port, step core and result queue
// depends on ymr_pkg, ymr_if, ymr_core, ymr_outq
`timescale 1ns / 1ps
// channel  | dir | signals
// in_      | in  | valid, ready, action, rx_byte
// out_     | out | valid, ready, kind .. last
// cfg_     | in  | valid, ready, index, data
// one item is taken per cycle while in ready is high; its state update is done in that cycle.
// its up to three results leave one per cycle, while out ready is high, from a two-batch queue.
// in ready drops only while the queue holds two batches (output stalled).
// synchronous active-low reset; cfg ready is always high.
module ymodem_receiver (
  input  logic     clk,
  input  logic     rst_n,
  ymr_in_if.sink   in_ch,
  ymr_out_if.source out_ch,
  ymr_cfg_if.sink  cfg_ch
);
  ymr_pkg::batch_t  batch;
  ymr_pkg::result_t res;
  logic             take, can_take;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = can_take;
  assign take = in_ch.valid && can_take;

  ymr_core u_core (
    .clk(clk), .rst_n(rst_n), .step(take), .action(in_ch.action),
    .rx_byte(in_ch.rx_byte), .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index),
    .cfg_data(cfg_ch.data), .batch(batch)
  );

  ymr_outq u_outq (
    .clk(clk), .rst_n(rst_n), .push(take), .batch_in(batch), .can_take(can_take),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );

  // result fields
  assign out_ch.kind = res.kind;
  assign out_ch.tx_byte = res.tx_byte;
  assign out_ch.data_byte = res.data_byte;
  assign out_ch.block_number = res.block_number;
  assign out_ch.accepted = res.accepted;
  assign out_ch.file_bytes = res.file_bytes;
  assign out_ch.error_code = res.error_code;
  assign out_ch.last = res.last;
endmodule

>>> rtl/core/ymr_core.sv
// protocol state and per-item step logic: one accepted item gives a batch of results
// depends on ymr_pkg
`timescale 1ns / 1ps
module ymr_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [1:0]          action,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  output ymr_pkg::batch_t     batch
);
  logic [31:0] init_to_r, recv_to_r;
  logic [15:0] poll_iv_r;
  logic        long_en_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [10:0] off_r, off_nxt;
  logic        long_r, long_nxt;
  logic [7:0]  exp_r, exp_nxt, seen_r, seen_nxt, crch_r, crch_nxt;
  logic        bval_r, bval_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [15:0] poll_r, poll_nxt;
  logic [31:0] size_r, size_nxt;
  logic [1:0]  hf_r, hf_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_to_r <= 32'd10000;
      recv_to_r <= 32'd3000;
      poll_iv_r <= 16'd1000;
      long_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ymr_pkg::REG_INIT_TO: init_to_r <= cfg_data;
        ymr_pkg::REG_RECV_TO: recv_to_r <= cfg_data;
        ymr_pkg::REG_POLL:    poll_iv_r <= cfg_data[15:0];
        ymr_pkg::REG_LONG:    long_en_r <= cfg_data[0];
      endcase
    end
  end

  // step logic
  logic [10:0] len;
  logic [7:0]  expect_num;
  logic [31:0] tick_inc, limit;
  logic [35:0] size_mul;
  logic [15:0] poll_inc;
  logic        ok;
  ymr_pkg::result_t r0, r1, r2;
  logic [1:0]  n;

  always_comb begin
    phase_nxt = phase_r; off_nxt = off_r; long_nxt = long_r; exp_nxt = exp_r;
    seen_nxt = seen_r; crch_nxt = crch_r; bval_nxt = bval_r; crc_nxt = crc_r;
    tick_nxt = tick_r; poll_nxt = poll_r; size_nxt = size_r; hf_nxt = hf_r;
    r0 = '0; r1 = '0; r2 = '0; n = 2'd0;
    len = long_r ? 11'(ymr_pkg::LONG_BLOCK_BYTES) : 11'(ymr_pkg::SHORT_BLOCK_BYTES);
    expect_num = (phase_r == ymr_pkg::PH_DATA) ? exp_r + 8'd1 : 8'd0;
    tick_inc = (tick_r == 32'hFFFF_FFFF) ? tick_r : tick_r + 32'd1;
    limit = (phase_r == ymr_pkg::PH_INIT) ? init_to_r : recv_to_r;
    size_mul = {4'd0, size_r} * 36'd10 + {28'd0, rx_byte - 8'h30};
    poll_inc = poll_r + 16'd1;
    ok = bval_r && ({crch_r, rx_byte} == crc_r);
    if (step) begin
      if (action == ymr_pkg::ACT_START) begin
        phase_nxt = ymr_pkg::PH_INIT; off_nxt = '0; long_nxt = 1'b0; exp_nxt = '0;
        tick_nxt = '0; poll_nxt = '0; bval_nxt = 1'b0; hf_nxt = '0; size_nxt = '0;
        r0 = ymr_pkg::mk(ymr_pkg::K_TX, ymr_pkg::CH_POLL, 0, 0, 0, 0, 0); n = 2'd1;
      end else if (phase_r != ymr_pkg::PH_STOP && action == ymr_pkg::ACT_TICK) begin
        tick_nxt = tick_inc;
        if (tick_inc >= limit) begin
          r0 = ymr_pkg::mk(ymr_pkg::K_ERROR, 0, 0, 0, 0, 0, 2'(phase_r - 3'd1)); n = 2'd1;
          phase_nxt = ymr_pkg::PH_STOP; off_nxt = '0; long_nxt = 1'b0; exp_nxt = '0;
        end else if (phase_r == ymr_pkg::PH_INIT) begin
          poll_nxt = poll_inc;
          if (poll_inc >= poll_iv_r) begin
            poll_nxt = '0;
            r0 = ymr_pkg::mk(ymr_pkg::K_TX, ymr_pkg::CH_POLL, 0, 0, 0, 0, 0); n = 2'd1;
          end
        end
      end else if (phase_r != ymr_pkg::PH_STOP && action == ymr_pkg::ACT_BYTE) begin
        if (phase_r == ymr_pkg::PH_INIT) begin
          if (rx_byte == ymr_pkg::CH_SOH) begin
            phase_nxt = ymr_pkg::PH_HEAD; tick_nxt = '0;
            long_nxt = 1'b0; off_nxt = 11'd1; bval_nxt = 1'b1; crc_nxt = '0;
            hf_nxt = '0; size_nxt = '0;
          end
        end else if (off_r != 11'd0) begin
          off_nxt = off_r + 11'd1;
          if (off_r == 11'd1) begin
            seen_nxt = rx_byte;
            if (rx_byte != expect_num) bval_nxt = 1'b0;
          end else if (off_r == 11'd2) begin
            if (rx_byte != ~seen_r) bval_nxt = 1'b0;
          end else if (off_r < len + 11'd3) begin
            crc_nxt = ymr_pkg::crc_add(crc_r, rx_byte);
            if (phase_r == ymr_pkg::PH_DATA) begin
              r0 = ymr_pkg::mk(ymr_pkg::K_PAYLOAD, 0, rx_byte, seen_r, 0, 0, 0); n = 2'd1;
            end else if (phase_r == ymr_pkg::PH_HEAD) begin
              if (hf_r == 2'd0) begin
                if (rx_byte == 8'd0) hf_nxt = 2'd1;
                else begin
                  r0 = ymr_pkg::mk(ymr_pkg::K_NAME, 0, rx_byte, seen_r, 0, 0, 0); n = 2'd1;
                end
              end else if (hf_r == 2'd1) begin
                if (rx_byte >= 8'h30 && rx_byte <= 8'h39)
                  size_nxt = (size_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : size_mul[31:0];
                else hf_nxt = 2'd2;
              end
            end
          end else if (off_r == len + 11'd3) begin
            crch_nxt = rx_byte;
          end else begin
            off_nxt = '0;
            if (!ok) begin
              r0 = ymr_pkg::mk(ymr_pkg::K_VERDICT, 0, 0, seen_r, 0, 0, 0); n = 2'd1;
            end else if (phase_r == ymr_pkg::PH_HEAD) begin
              r0 = ymr_pkg::mk(ymr_pkg::K_SIZE, 0, 0, 0, 0, size_r, 0);
              r1 = ymr_pkg::mk(ymr_pkg::K_TX, ymr_pkg::CH_ACK, 0, 0, 0, 0, 0);
              r2 = ymr_pkg::mk(ymr_pkg::K_TX, ymr_pkg::CH_POLL, 0, 0, 0, 0, 0); n = 2'd3;
              exp_nxt = '0; phase_nxt = ymr_pkg::PH_DATA; tick_nxt = '0;
            end else if (phase_r == ymr_pkg::PH_DATA) begin
              exp_nxt = exp_r + 8'd1;
              r0 = ymr_pkg::mk(ymr_pkg::K_VERDICT, 0, 0, seen_r, 1'b1, 0, 0);
              r1 = ymr_pkg::mk(ymr_pkg::K_TX, ymr_pkg::CH_ACK, 0, 0, 0, 0, 0); n = 2'd2;
              tick_nxt = '0;
            end else begin
              r0 = ymr_pkg::mk(ymr_pkg::K_TX, ymr_pkg::CH_ACK, 0, 0, 0, 0, 0);
              r1 = ymr_pkg::mk(ymr_pkg::K_END, 0, 0, 0, 0, 0, 0); n = 2'd2;
              phase_nxt = ymr_pkg::PH_STOP; long_nxt = 1'b0; exp_nxt = '0;
            end
          end
        end else if (rx_byte == ymr_pkg::CH_SOH || (rx_byte == ymr_pkg::CH_STX &&
                     phase_r == ymr_pkg::PH_DATA && long_en_r)) begin
          long_nxt = (rx_byte == ymr_pkg::CH_STX); off_nxt = 11'd1; bval_nxt = 1'b1;
          crc_nxt = '0; hf_nxt = '0; size_nxt = '0;
        end else if (rx_byte == ymr_pkg::CH_EOT && phase_r == ymr_pkg::PH_DATA) begin
          phase_nxt = ymr_pkg::PH_END; tick_nxt = '0;
          r0 = ymr_pkg::mk(ymr_pkg::K_TX, ymr_pkg::CH_NAK, 0, 0, 0, 0, 0); n = 2'd1;
        end else if (rx_byte == ymr_pkg::CH_EOT && phase_r == ymr_pkg::PH_END) begin
          r0 = ymr_pkg::mk(ymr_pkg::K_TX, ymr_pkg::CH_ACK, 0, 0, 0, 0, 0);
          r1 = ymr_pkg::mk(ymr_pkg::K_TX, ymr_pkg::CH_POLL, 0, 0, 0, 0, 0); n = 2'd2;
        end
      end
    end
    // mark final result of the step
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
    if (n == 2'd3) r2.last = 1'b1;
    batch.count = n; batch.r0 = r0; batch.r1 = r1; batch.r2 = r2;
  end

  // protocol state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ymr_pkg::PH_STOP; off_r <= '0; long_r <= 1'b0; exp_r <= '0;
      seen_r <= '0; bval_r <= 1'b0; crc_r <= '0; crch_r <= '0; tick_r <= '0;
      poll_r <= '0; size_r <= '0; hf_r <= '0;
    end else begin
      phase_r <= phase_nxt; off_r <= off_nxt; long_r <= long_nxt; exp_r <= exp_nxt;
      seen_r <= seen_nxt; bval_r <= bval_nxt; crc_r <= crc_nxt; crch_r <= crch_nxt;
      tick_r <= tick_nxt; poll_r <= poll_nxt; size_r <= size_nxt; hf_r <= hf_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ymr_pkg::PH_STOP |-> off_r == 11'd0) else $error("offset open while stopped");
  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    off_r <= 11'(ymr_pkg::LONG_BLOCK_BYTES) + 11'd4) else $error("offset out of range");
  a_short_init: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ymr_pkg::PH_INIT |-> !long_r) else $error("long block in init");
`endif
endmodule

>>> rtl/core/ymr_outq.sv
// result queue: holds up to two batches and sends one result per transfer
// depends on ymr_pkg
`timescale 1ns / 1ps
module ymr_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ymr_pkg::batch_t     batch_in,
  output logic                can_take,
  output logic                out_valid,
  input  logic                out_ready,
  output ymr_pkg::result_t    out_res
);
  ymr_pkg::batch_t slot_r [2];
  logic            rd_r, wr_r;
  logic [1:0]      cnt_r;
  logic [1:0]      idx_r;
  ymr_pkg::batch_t head;
  logic            pop_res, pop_batch;

  assign head = slot_r[rd_r];
  assign out_valid = cnt_r != 2'd0;
  always_comb begin
    unique case (idx_r)
      2'd0: out_res = head.r0;
      2'd1: out_res = head.r1;
      default: out_res = head.r2;
    endcase
  end
  assign pop_res = out_valid && out_ready;
  assign pop_batch = pop_res && (idx_r + 2'd1 == head.count);
  // room for a worst-case batch
  assign can_take = cnt_r != 2'd2;

  // slot storage
  always_ff @(posedge clk) begin
    if (push && batch_in.count != 2'd0) slot_r[wr_r] <= batch_in;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= '0; idx_r <= '0;
    end else begin
      if (push && batch_in.count != 2'd0) wr_r <= ~wr_r;
      if (pop_batch) begin
        rd_r <= ~rd_r; idx_r <= '0;
      end else if (pop_res) idx_r <= idx_r + 2'd1;
      cnt_r <= cnt_r + 2'(push && batch_in.count != 2'd0) - 2'(pop_batch);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> idx_r < head.count) else $error("index past batch");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop_batch |-> out_res.last) else $error("batch end without last");
`endif
endmodule

>>> verif/ymr_reply_checker.sv
// reply checker for the ymodem receiver: predicts every result and compares
// depends on ymr_pkg and the channel interfaces in ymr_if
`timescale 1ns / 1ps
package ymr_tb_pkg;
  // crc-16 (poly 0x1021) advanced by one byte, msb first
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return c;
  endfunction
endpackage

module ymr_reply_checker
  import ymr_pkg::*;
  import ymr_tb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ymr_in_if    in_ch,
  ymr_out_if   out_ch,
  ymr_cfg_if   cfg_ch,
  output int   fail_count,
  output int   waiting,
  output int   items_seen,
  output int   replies_seen
);

  // register copies
  logic [31:0] init_to, recv_to;
  logic [15:0] poll_iv;
  logic        long_en;

  // receiver state copy
  logic [2:0]  phase;
  logic [10:0] offset;
  logic        long_blk, blk_ok;
  logic [7:0]  exp_blk, seen_blk, crc_hi;
  logic [15:0] crc_run, polls;
  logic [31:0] ticks, size_acc;
  logic [1:0]  hfield;

  result_t expected_replies[$];
  result_t step_replies[$];

  task automatic emit(input logic [2:0] kind, input logic [7:0] tx, input logic [7:0] data,
                      input logic [7:0] blk, input logic acc, input logic [31:0] size,
                      input logic [1:0] err);
    result_t r;
    r = '0;
    r.kind = kind;
    r.tx_byte = tx;
    r.data_byte = data;
    r.block_number = blk;
    r.accepted = acc;
    r.file_bytes = size;
    r.error_code = err;
    step_replies.push_back(r);
  endtask

  task automatic end_session();
    phase = PH_STOP;
    offset = '0;
    long_blk = 1'b0;
    exp_blk = '0;
  endtask

  task automatic begin_block(input logic is_long);
    long_blk = is_long;
    offset = 11'd1;
    blk_ok = 1'b1;
    crc_run = '0;
    hfield = '0;
    size_acc = '0;
  endtask

  // one byte inside an open block
  task automatic take_block_byte(input logic [7:0] b);
    int len;
    int off;
    logic [7:0] want;
    logic [63:0] v;
    len = long_blk ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES;
    off = offset;
    want = (phase == PH_DATA) ? exp_blk + 8'd1 : 8'd0;
    if (off == 1) begin
      seen_blk = b;
      if (b != want) blk_ok = 1'b0;
    end else if (off == 2) begin
      if (b != ~seen_blk) blk_ok = 1'b0;
    end else if (off < 3 + len) begin
      crc_run = crc16_next(crc_run, b);
      if (phase == PH_DATA) begin
        emit(K_PAYLOAD, 0, b, seen_blk, 0, 0, 0);
      end else if (phase == PH_HEAD) begin
        if (hfield == 0) begin
          if (b == 0) hfield = 1;
          else emit(K_NAME, 0, b, seen_blk, 0, 0, 0);
        end else if (hfield == 1) begin
          if (b >= 8'h30 && b <= 8'h39) begin
            v = 64'(size_acc) * 10 + 64'(b - 8'h30);
            size_acc = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
          end else begin
            hfield = 2;
          end
        end
      end
    end else if (off == 3 + len) begin
      crc_hi = b;
    end else begin
      offset = '0;
      if (!(blk_ok && {crc_hi, b} == crc_run)) begin
        emit(K_VERDICT, 0, 0, seen_blk, 0, 0, 0);
      end else if (phase == PH_HEAD) begin
        emit(K_SIZE, 0, 0, 0, 0, size_acc, 0);
        emit(K_TX, CH_ACK, 0, 0, 0, 0, 0);
        emit(K_TX, CH_POLL, 0, 0, 0, 0, 0);
        exp_blk = '0;
        phase = PH_DATA;
        ticks = '0;
      end else if (phase == PH_DATA) begin
        exp_blk = exp_blk + 8'd1;
        emit(K_VERDICT, 0, 0, seen_blk, 1, 0, 0);
        emit(K_TX, CH_ACK, 0, 0, 0, 0, 0);
        ticks = '0;
      end else begin
        emit(K_TX, CH_ACK, 0, 0, 0, 0, 0);
        emit(K_END, 0, 0, 0, 0, 0, 0);
        end_session();
      end
      return;
    end
    offset = 11'(off + 1);
  endtask

  task automatic take_tick();
    logic [31:0] limit;
    logic [1:0] code;
    limit = (phase == PH_INIT) ? init_to : recv_to;
    if (ticks != 32'hFFFF_FFFF) ticks = ticks + 1;
    if (ticks >= limit) begin
      code = 2'(phase - 3'd1);
      end_session();
      emit(K_ERROR, 0, 0, 0, 0, 0, code);
      return;
    end
    if (phase == PH_INIT) begin
      polls = polls + 1;
      if (polls >= poll_iv) begin
        polls = '0;
        emit(K_TX, CH_POLL, 0, 0, 0, 0, 0);
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    if (phase == PH_INIT) begin
      if (b == CH_SOH) begin
        phase = PH_HEAD;
        ticks = '0;
        begin_block(1'b0);
      end
    end else if (offset != 0) begin
      take_block_byte(b);
    end else if (b == CH_SOH) begin
      begin_block(1'b0);
    end else if (b == CH_STX && phase == PH_DATA && long_en) begin
      begin_block(1'b1);
    end else if (b == CH_EOT && phase == PH_DATA) begin
      phase = PH_END;
      ticks = '0;
      emit(K_TX, CH_NAK, 0, 0, 0, 0, 0);
    end else if (b == CH_EOT && phase == PH_END) begin
      emit(K_TX, CH_ACK, 0, 0, 0, 0, 0);
      emit(K_TX, CH_POLL, 0, 0, 0, 0, 0);
    end
  endtask

  // predict the results of one input transfer
  task automatic predict_receiver(input logic [1:0] act, input logic [7:0] b);
    result_t r;
    step_replies.delete();
    if (act == ACT_START) begin
      end_session();
      phase = PH_INIT;
      ticks = '0;
      polls = '0;
      blk_ok = 1'b0;
      hfield = '0;
      size_acc = '0;
      emit(K_TX, CH_POLL, 0, 0, 0, 0, 0);
    end else if (phase >= PH_INIT && phase <= PH_END) begin
      if (act == ACT_BYTE) take_byte(b);
      else if (act == ACT_TICK) take_tick();
    end
    if (step_replies.size() > 0) begin
      r = step_replies.pop_back();
      r.last = 1'b1;
      step_replies.push_back(r);
    end
    foreach (step_replies[i]) expected_replies.push_back(step_replies[i]);
  endtask

  task automatic cmp(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $realtime, name, e, a);
      fail_count++;
    end
  endtask

  // watch the channels on every edge
  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      init_to = 32'd10000;
      recv_to = 32'd3000;
      poll_iv = 16'd1000;
      long_en = 1'b1;
      end_session();
      seen_blk = '0;
      blk_ok = 1'b0;
      crc_run = '0;
      crc_hi = '0;
      ticks = '0;
      polls = '0;
      size_acc = '0;
      hfield = '0;
      expected_replies.delete();
      fail_count = 0;
      items_seen = 0;
      replies_seen = 0;
      waiting <= 0;
    end else begin
      // register write transfer
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_INIT_TO: init_to = cfg_ch.data;
          REG_RECV_TO: recv_to = cfg_ch.data;
          REG_POLL: poll_iv = cfg_ch.data[15:0];
          REG_LONG: long_en = cfg_ch.data[0];
          default: ;
        endcase
      end
      // input transfer
      if (in_ch.valid && in_ch.ready) begin
        predict_receiver(in_ch.action, in_ch.rx_byte);
        items_seen++;
      end
      // result transfer
      if (out_ch.valid && out_ch.ready) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          $display("%0t: result kind %0d arrived with nothing expected", $realtime,
                   out_ch.kind);
          fail_count++;
        end else begin
          e = expected_replies.pop_front();
          cmp("kind", e.kind, out_ch.kind);
          cmp("tx_byte", e.tx_byte, out_ch.tx_byte);
          cmp("data_byte", e.data_byte, out_ch.data_byte);
          cmp("block_number", e.block_number, out_ch.block_number);
          cmp("accepted", e.accepted, out_ch.accepted);
          cmp("file_bytes", e.file_bytes, out_ch.file_bytes);
          cmp("error_code", e.error_code, out_ch.error_code);
          cmp("last", e.last, out_ch.last);
        end
      end
      waiting <= expected_replies.size();
    end
  end

endmodule

>>> verif/testbench.sv
// stimulus and verdict for the ymodem receiver
// depends on ymr_pkg, ymr_if, ymodem_receiver and ymr_reply_checker
`timescale 1ns / 1ps
module testbench;
  import ymr_pkg::*;
  import ymr_tb_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  // action code with no meaning, must be ignored
  localparam logic [1:0] ACT_NONE = 2'd3;

  logic clk;
  logic rst_n;

  ymr_in_if  in_ch();
  ymr_out_if out_ch();
  ymr_cfg_if cfg_ch();

  int fail_count, waiting, items_seen, replies_seen;
  int idle_cycles;
  int sessions;
  int tick_odds;
  bit tx_quiet, rx_quiet, hold_req, long_on;
  logic [7:0] body[0:1023];

  ymodem_receiver i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  ymr_reply_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count  (fail_count),
    .waiting     (waiting),
    .items_seen  (items_seen),
    .replies_seen(replies_seen)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout with %0d results outstanding", waiting);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) rx_quiet = ~rx_quiet;
      n = rx_quiet ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  // one input transfer after a random gap
  task automatic send(input logic [1:0] act, input logic [7:0] b);
    int n;
    if ($urandom_range(0, 63) == 0) tx_quiet = ~tx_quiet;
    n = tx_quiet ? 0 : $urandom_range(0, 11);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send(ACT_BYTE, b);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send(ACT_TICK, 8'($urandom_range(0, 255)));
  endtask

  // stop offering and wait until every expected result has come
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [31:0] init_to, input logic [31:0] recv_to,
                           input logic [31:0] poll, input logic long_en);
    drain();
    write_reg(REG_INIT_TO, init_to);
    write_reg(REG_RECV_TO, recv_to);
    write_reg(REG_POLL, poll);
    write_reg(REG_LONG, {31'd0, long_en});
    long_on = long_en;
  endtask

  // header body: name, nul, decimal digits, a separator, then junk
  task automatic fill_header(input int name_len, input int ndigits);
    int p;
    for (int i = 0; i < 128; i++) body[i] = 8'($urandom_range(0, 255));
    for (p = 0; p < name_len; p++) body[p] = 8'($urandom_range(1, 255));
    body[p] = 8'h00;
    for (int i = 1; i <= ndigits; i++) body[p + i] = 8'h30 + 8'($urandom_range(0, 9));
    body[p + ndigits + 1] = 8'h20;
  endtask

  task automatic fill_payload(input int len);
    for (int i = 0; i < len; i++) body[i] = 8'($urandom_range(0, 255));
  endtask

  // flaw: 0 good, 1 bad complement, 2 bad crc, 3 wrong number
  task automatic send_block(input logic [7:0] start, input logic [7:0] num, input int len,
                            input int flaw);
    logic [15:0] crc;
    logic [7:0] n;
    crc = '0;
    n = (flaw == 3) ? num + 8'd1 : num;
    send_byte(start);
    send_byte(n);
    send_byte(flaw == 1 ? n ^ 8'h5A : ~n);
    for (int i = 0; i < len; i++) begin
      crc = crc16_next(crc, body[i]);
      if (tick_odds != 0 && $urandom_range(0, tick_odds) == 0) send_ticks(1);
      send_byte(body[i]);
    end
    if (flaw == 2) crc = crc ^ 16'($urandom_range(1, 65535));
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  // a byte between blocks that must be ignored
  task automatic send_noise();
    if (!long_on && $urandom_range(0, 2) == 0) send_byte(CH_STX);
    else send_byte(8'($urandom_range(5, 255)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_START;
    in_ch.rx_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_INIT_TO;
    cfg_ch.data = 32'd0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    hold_req = 1'b0;
    long_on = 1'b1;
    tick_odds = 0;
    sessions = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes, ticks and the unused action while stopped
    send_byte(CH_SOH);
    send_ticks(1);
    send(ACT_NONE, 8'hFF);

    // initiate timeout with polling, restart, unused action mid-session
    write_all(32'd6, 32'd5, 32'd2, 1'b1);
    send(ACT_START, 8'h00);
    send_ticks(6);
    send(ACT_START, 8'h00);
    send(ACT_START, 8'h00);
    send(ACT_NONE, 8'h00);
    // zero poll interval polls on every tick
    write_all(32'd6, 32'd5, 32'd0, 1'b1);
    send(ACT_START, 8'h00);
    send_ticks(2);
    // zero timeout fails on the first tick
    write_all(32'd0, 32'd5, 32'd1, 1'b1);
    send(ACT_START, 8'h00);
    send_ticks(1);

    // header timeout inside an open block
    write_all(32'd100, 32'd5, 32'd1, 1'b1);
    send(ACT_START, 8'h00);
    send_byte(CH_SOH);
    send_ticks(5);

    // one session: header, a data block under a held-off output, end handshake
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65535, 1'b0);
    tick_odds = 30;
    sessions++;
    send(ACT_START, 8'h00);
    send_ticks(2);
    send_noise();
    fill_header($urandom_range(3, 12), 12);
    send_block(CH_SOH, 8'd0, 128, 0);
    send_noise();
    fill_payload(128);
    hold_req = 1'b1;
    send_block(CH_SOH, 8'd1, 128, $urandom_range(0, 3));
    send_byte(CH_EOT);
    send_noise();
    send_byte(CH_EOT);
    // final block cut short, then the end timeout
    send_byte(CH_SOH);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    drain();
    write_reg(REG_RECV_TO, 32'd3);
    send_ticks(3);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d sessions: %0d input transfers, %0d results checked",
             sessions, items_seen, replies_seen);
    $display("including polling, timeouts, header parsing, a data block and a held-off output");
    if (fail_count == 0 && waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
